// ----- design/akf_pkg.sv -----
package akf_pkg;

	localparam int COV_FRAC_BITS = 24;
	// numerator of a gain: a 32-bit magnitude shifted up by the fraction bits
	localparam int DIV_NUM_W     = 32 + COV_FRAC_BITS;
	localparam int DIV_CNT_W     = $clog2(DIV_NUM_W);
	localparam int PADDR_W       = 4;

	localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd0;
	localparam logic [1:0] REG_ANGLE_NOISE   = 2'd1;
	localparam logic [1:0] REG_BIAS_NOISE    = 2'd2;
	localparam logic [1:0] REG_MEASURE_NOISE = 2'd3;

	localparam logic [30:0] RST_SAMPLE_PERIOD = 31'd167772;
	localparam logic [30:0] RST_ANGLE_NOISE   = 31'd16777;
	localparam logic [30:0] RST_BIAS_NOISE    = 31'd83886;
	localparam logic [30:0] RST_MEASURE_NOISE = 31'd8388608;

	localparam logic signed [31:0] COV_ONE = 32'sd1 <<< COV_FRAC_BITS;

	typedef struct packed {
		logic signed [31:0] measured_angle;
		logic signed [31:0] gyro_rate;
	} akf_in_t;

	typedef struct packed {
		logic signed [31:0] fused_angle;
		logic signed [31:0] corrected_rate;
		logic               saturated;
	} akf_out_t;

	typedef struct packed {
		logic [30:0] sample_period;
		logic [30:0] angle_process_noise;
		logic [30:0] bias_process_noise;
		logic [30:0] measure_noise;
	} akf_cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_WB,
		ST_DIV,
		ST_DONE
	} akf_state_t;

	typedef enum logic [3:0] {
		OP_ANG,
		OP_P00,
		OP_PX,
		OP_P11,
		OP_C00,
		OP_C01,
		OP_C10,
		OP_C11,
		OP_CANG,
		OP_CBIAS
	} akf_op_t;

	typedef struct packed {
		logic    load;
		logic    mul;
		logic    wb;
		logic    div_start;
		logic    out_load;
		akf_op_t op;
	} akf_cmd_t;

	typedef struct packed {
		logic div_done;
	} akf_status_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	function automatic logic ovf32(input logic signed [63:0] v);
		return (v > 64'sd2147483647) || (v < -64'sd2147483648);
	endfunction

endpackage

// ----- design/akf_regs.sv -----
module akf_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [akf_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output akf_pkg::akf_cfg_t           cfg
);
	import akf_pkg::*;

	akf_cfg_t    cfg_q;
	logic        wr_en;
	logic [1:0]  idx;

	assign wr_en = psel && penable && pwrite;
	assign idx   = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_period       <= RST_SAMPLE_PERIOD;
			cfg_q.angle_process_noise <= RST_ANGLE_NOISE;
			cfg_q.bias_process_noise  <= RST_BIAS_NOISE;
			cfg_q.measure_noise       <= RST_MEASURE_NOISE;
		end else if (wr_en) begin
			unique case (idx)
				REG_SAMPLE_PERIOD: cfg_q.sample_period       <= pwdata[30:0];
				REG_ANGLE_NOISE:   cfg_q.angle_process_noise <= pwdata[30:0];
				REG_BIAS_NOISE:    cfg_q.bias_process_noise  <= pwdata[30:0];
				REG_MEASURE_NOISE: cfg_q.measure_noise       <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SAMPLE_PERIOD: prdata = {1'b0, cfg_q.sample_period};
			REG_ANGLE_NOISE:   prdata = {1'b0, cfg_q.angle_process_noise};
			REG_BIAS_NOISE:    prdata = {1'b0, cfg_q.bias_process_noise};
			REG_MEASURE_NOISE: prdata = {1'b0, cfg_q.measure_noise};
			default:           prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ----- design/akf_ctrl.sv -----
module akf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output akf_pkg::akf_cmd_t    cmd,
	input  akf_pkg::akf_status_t status
);
	import akf_pkg::*;

	akf_state_t state_q, state_d;
	akf_op_t    op_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_MUL;
			ST_MUL:  state_d = ST_WB;
			ST_WB: begin
				if (op_q == OP_P11)
					state_d = ST_DIV;
				else if (op_q == OP_CBIAS)
					state_d = ST_DONE;
				else
					state_d = ST_MUL;
			end
			ST_DIV:  if (status.div_done) state_d = ST_MUL;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.op        = op_q;
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.mul       = (state_q == ST_MUL);
		cmd.wb        = (state_q == ST_WB);
		cmd.div_start = (state_q == ST_WB) && (op_q == OP_P11);
		cmd.out_load  = (state_q == ST_DONE) && out_free;
		in_stall      = (state_q != ST_IDLE);
		out_valid     = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_ANG;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				op_q <= OP_ANG;
			else if ((state_q == ST_WB && op_q != OP_P11 && op_q != OP_CBIAS)
					|| (state_q == ST_DIV && status.div_done))
				op_q <= akf_op_t'(op_q + 4'd1);
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- design/akf_div.sv -----
module akf_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [31:0]  num0,
	input  logic signed [31:0]  num1,
	input  logic signed [32:0]  den,
	output logic                done,
	output logic signed [31:0]  quo0,
	output logic signed [31:0]  quo1,
	output logic                clip
);
	import akf_pkg::*;

	logic [DIV_NUM_W-1:0] n0_q, n1_q, q0_q, q1_q;
	logic [31:0]          rem0_q, rem1_q, den_q;
	logic                 neg0_q, neg1_q, zero_q, busy_q, done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [32:0]          mag0, mag1, trial0, trial1;
	logic                 ge0, ge1;
	logic signed [63:0]   s0, s1;

	assign mag0   = num0[31] ? -33'(num0) : 33'(num0);
	assign mag1   = num1[31] ? -33'(num1) : 33'(num1);
	assign trial0 = {rem0_q, n0_q[DIV_NUM_W-1]};
	assign trial1 = {rem1_q, n1_q[DIV_NUM_W-1]};
	assign ge0    = trial0 >= {1'b0, den_q};
	assign ge1    = trial1 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// one quotient bit per lane per cycle, both lanes share the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			n0_q   <= {mag0[31:0], {COV_FRAC_BITS{1'b0}}};
			n1_q   <= {mag1[31:0], {COV_FRAC_BITS{1'b0}}};
			q0_q   <= '0;
			q1_q   <= '0;
			rem0_q <= '0;
			rem1_q <= '0;
			den_q  <= den[31:0];
			neg0_q <= num0[31];
			neg1_q <= num1[31];
			zero_q <= den[32] || (den == 33'sd0);
		end else if (busy_q) begin
			n0_q   <= {n0_q[DIV_NUM_W-2:0], 1'b0};
			n1_q   <= {n1_q[DIV_NUM_W-2:0], 1'b0};
			q0_q   <= {q0_q[DIV_NUM_W-2:0], ge0};
			q1_q   <= {q1_q[DIV_NUM_W-2:0], ge1};
			rem0_q <= ge0 ? 32'(trial0 - {1'b0, den_q}) : trial0[31:0];
			rem1_q <= ge1 ? 32'(trial1 - {1'b0, den_q}) : trial1[31:0];
		end
	end

	always_comb begin
		s0 = signed'(64'(q0_q));
		s1 = signed'(64'(q1_q));
		if (neg0_q) s0 = -s0;
		if (neg1_q) s1 = -s1;
		if (zero_q) begin
			quo0 = '0;
			quo1 = '0;
			clip = 1'b0;
		end else begin
			quo0 = sat32(s0);
			quo1 = sat32(s1);
			clip = ovf32(s0) || ovf32(s1);
		end
	end

	assign done = done_q;

endmodule

// ----- design/akf_dp.sv -----
module akf_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  akf_pkg::akf_cfg_t    cfg,
	input  akf_pkg::akf_cmd_t    cmd,
	output akf_pkg::akf_status_t status,
	input  akf_pkg::akf_in_t     in_data,
	output akf_pkg::akf_out_t    out_data
);
	import akf_pkg::*;

	logic signed [31:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	logic signed [31:0] err_q, t0_q, t1_q, meas_q, rate_q;
	logic               clip_q;
	logic signed [65:0] prod_q;
	akf_out_t           out_q;

	logic signed [32:0] opa, opb;
	logic               clip_a;
	logic signed [63:0] diff_a, rnd, acc, acc2, corr_w;
	logic signed [31:0] k0, k1, ang_new;
	logic               div_done, div_clip;
	logic signed [32:0] e;

	akf_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num0  (p00_q),
		.num1  (p10_q),
		.den   (e),
		.done  (div_done),
		.quo0  (k0),
		.quo1  (k1),
		.clip  (div_clip)
	);

	assign e = 33'(signed'({1'b0, cfg.measure_noise})) + 33'(p00_q);
	assign status.div_done = div_done;

	// operand select for the shared multiplier
	always_comb begin
		diff_a = '0;
		clip_a = 1'b0;
		opa    = '0;
		opb    = 33'(signed'({1'b0, cfg.sample_period}));
		case (cmd.op)
			OP_ANG: begin
				diff_a = 64'(rate_q) - 64'(bias_q);
				opa    = 33'(sat32(diff_a));
				clip_a = ovf32(diff_a);
			end
			OP_P00: begin
				diff_a = 64'(signed'({1'b0, cfg.angle_process_noise}))
					- 64'(p01_q) - 64'(p10_q);
				opa    = 33'(sat32(diff_a));
				clip_a = ovf32(diff_a);
			end
			OP_PX:    opa = -33'(p11_q);
			OP_P11:   opa = 33'(signed'({1'b0, cfg.bias_process_noise}));
			OP_C00:   begin opa = 33'(k0); opb = 33'(t0_q);  end
			OP_C01:   begin opa = 33'(k0); opb = 33'(t1_q);  end
			OP_C10:   begin opa = 33'(k1); opb = 33'(t0_q);  end
			OP_C11:   begin opa = 33'(k1); opb = 33'(t1_q);  end
			OP_CANG:  begin opa = 33'(k0); opb = 33'(err_q); end
			OP_CBIAS: begin opa = 33'(k1); opb = 33'(err_q); end
			default: ;
		endcase
	end

	// round to nearest, ties up, then drop the fraction bits
	assign rnd = 64'((prod_q + (66'sd1 <<< (COV_FRAC_BITS - 1))) >>> COV_FRAC_BITS);

	always_comb begin
		acc = '0;
		case (cmd.op)
			OP_ANG, OP_CANG:  acc = 64'(ang_q) + (cmd.op == OP_ANG ? rnd : rnd);
			OP_P00:           acc = 64'(p00_q) + rnd;
			OP_PX:            acc = 64'(p01_q) + rnd;
			OP_P11:           acc = 64'(p11_q) + rnd;
			OP_C00:           acc = 64'(p00_q) - rnd;
			OP_C01:           acc = 64'(p01_q) - rnd;
			OP_C10:           acc = 64'(p10_q) - rnd;
			OP_C11:           acc = 64'(p11_q) - rnd;
			OP_CBIAS:         acc = 64'(bias_q) + rnd;
			default: ;
		endcase
		ang_new = sat32(acc);
		acc2    = (cmd.op == OP_PX) ? 64'(p10_q) + rnd : 64'(meas_q) - 64'(ang_new);
		corr_w  = 64'(rate_q) - 64'(bias_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_q  <= '0;
			bias_q <= '0;
			p00_q  <= COV_ONE;
			p01_q  <= '0;
			p10_q  <= '0;
			p11_q  <= COV_ONE;
			clip_q <= 1'b0;
		end else begin
			if (cmd.load)
				clip_q <= 1'b0;
			else if ((cmd.mul && clip_a) || (div_done && div_clip))
				clip_q <= 1'b1;
			else if (cmd.wb && (ovf32(acc) || ((cmd.op == OP_ANG || cmd.op == OP_PX)
					&& ovf32(acc2))))
				clip_q <= 1'b1;
			if (cmd.wb) begin
				case (cmd.op)
					OP_ANG, OP_CANG:  ang_q  <= ang_new;
					OP_P00, OP_C00:   p00_q  <= ang_new;
					OP_PX: begin
						p01_q <= ang_new;
						p10_q <= sat32(acc2);
					end
					OP_C01:           p01_q  <= ang_new;
					OP_C10:           p10_q  <= ang_new;
					OP_P11, OP_C11:   p11_q  <= ang_new;
					OP_CBIAS:         bias_q <= ang_new;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			meas_q <= in_data.measured_angle;
			rate_q <= in_data.gyro_rate;
		end
		if (cmd.mul)
			prod_q <= opa * opb;
		if (cmd.wb && cmd.op == OP_ANG)
			err_q <= sat32(acc2);
		// hold predicted P00 and P01 for the correction products
		if (cmd.div_start) begin
			t0_q <= p00_q;
			t1_q <= p01_q;
		end
		if (cmd.out_load) begin
			out_q.fused_angle    <= ang_q;
			out_q.corrected_rate <= sat32(corr_w);
			out_q.saturated      <= clip_q || ovf32(corr_w);
		end
	end

	assign out_data = out_q;

endmodule

// ----- design/angle_gyro_kalman_fusion.sv -----
// Two-state Kalman filter fusing an accelerometer angle with a gyro rate,
// tracking angle, gyro bias and a 2x2 covariance (Q16.16 angles, Q8.24
// covariances, gains and settings). One transaction in gives one result out.
// From acceptance to result, a sample goes through issue and write-back
// for ten products on a single shared 33x33 multiplier, starting and
// waiting on the restoring divider, which forms both gains in parallel at
// one bit per cycle, and the load of the output register. The next sample
// is taken only after that load. A finished result waits in the output
// register while the next sample is taken. Settings are to be written
// through the APB port while the block is idle; the block itself does
// not enforce this.
module angle_gyro_kalman_fusion (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  akf_pkg::akf_in_t            in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output akf_pkg::akf_out_t           out_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [akf_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import akf_pkg::*;

	akf_cfg_t    cfg;
	akf_cmd_t    cmd;
	akf_status_t status;

	assign pready = 1'b1;

	akf_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	akf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.status   (status)
	);

	akf_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cmd     (cmd),
		.status  (status),
		.in_data (in_data),
		.out_data(out_data)
	);

endmodule

// ----- design/akf_checker.sv -----
module akf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input akf_pkg::akf_out_t out_data
);
	import akf_pkg::*;

	// the block works on one sample at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a sample is in work");

	// a result only appears at the end of a sample's work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a sample in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule

bind angle_gyro_kalman_fusion akf_checker u_akf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);
